/* rtl/dcwc_pkg.sv */
// shared types and constants for the dctcp window controller
`timescale 1ns / 1ps
`default_nettype none

package dcwc_pkg;

  localparam int PSN_BITS        = 24;
  localparam int ALPHA_FRAC_BITS = 16;

  localparam int WIN_W     = 32;
  localparam int PKT_W     = 16;
  localparam int ALPHA_W   = ALPHA_FRAC_BITS + 1;
  localparam int GAIN_FRAC = 16;
  localparam int GAIN_W    = GAIN_FRAC + 1;
  localparam int CNT_W     = 32;

  localparam int DIV_W     = 32;
  localparam int STEP_W    = $clog2(DIV_W + 1);
  localparam int MUL_W     = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC_BITS;
  localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [WIN_W-1:0]   WIN_MAX   = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MODE   = 3'd0,
    CFG_PACKET_SIZE  = 3'd1,
    CFG_BASE_BDP     = 3'd2,
    CFG_START_WINDOW = 3'd3,
    CFG_AI_INCREMENT = 3'd4,
    CFG_GAIN         = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_ACK   = 1'b1
  } item_mode_e;

  typedef struct packed {
    logic                mode;
    logic                ecn_marked;
    logic [PSN_BITS-1:0] ack_psn;
    logic [PSN_BITS-1:0] sender_next_psn;
  } in_item_t;

  typedef struct packed {
    logic [WIN_W-1:0]   window_bytes;
    logic [ALPHA_W-1:0] alpha_value;
    logic               in_slow_start;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem;
    logic [DIV_W-1:0]  dvd;
    logic [DIV_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [2*MUL_W-1:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

/* rtl/dcwc_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module dcwc_div import dcwc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [STEP_W-1:0] count_q, count_d;
  logic              done_q, done_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  dvd_q, dvd_d;
  logic [DIV_W-1:0]  divisor_q, divisor_d;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_sub;
  logic              qbit;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, divisor_q};
    qbit    = (rem_sh >= {1'b0, divisor_q});
    count_d   = count_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    divisor_d = divisor_q;
    done_d    = 1'b0;
    if (req_i.start) begin
      count_d   = req_i.steps;
      rem_d     = req_i.rem;
      dvd_d     = req_i.dvd;
      divisor_d = req_i.divisor;
    end else if (count_q != '0) begin
      count_d = count_q - STEP_W'(1);
      rem_d   = qbit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      dvd_d   = {dvd_q[DIV_W-2:0], qbit};
      done_d  = (count_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    divisor_q <= divisor_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

/* rtl/dcwc_mul.sv */
// registered multiplier, operands captured, then product registered in the cycle after
`timescale 1ns / 1ps
`default_nettype none

module dcwc_mul import dcwc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mul_req_t req_i,
  output mul_rsp_t      rsp_o
);

  logic [MUL_W-1:0]   a_q, b_q;
  logic [2*MUL_W-1:0] prod_q;
  logic               stage_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= req_i.start;
      done_q  <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end
    prod_q <= a_q * b_q;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

endmodule

`default_nettype wire

/* rtl/dctcp_window_controller.sv */
// dctcp window controller top level: flow state, sequencer and output register
// start item or slow start ack: result registered in the output state, unless a stalled result holds it
// congestion avoidance ack: result passes, as needed, the 16-step marked fraction divide,
// the two alpha multiplies, and the window cut multiply or the two 32-step increase divides
// one item in work at a time: input stalls until the last result is in the output register
// reset puts the configuration at its defaults, alpha at one, other flow state and out valid at zero
`timescale 1ns / 1ps
`default_nettype none

module dctcp_window_controller import dcwc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int P1_W  = GAIN_W + ALPHA_W;
  localparam int SUM_W = P1_W + 1;
  localparam int RED_W = ALPHA_W + 1;
  localparam logic [RED_W-1:0] RED_ONE = RED_W'(1) << (ALPHA_FRAC_BITS + 1);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b00000000001,
    ST_CHECK     = 11'b00000000010,
    ST_RATIO_DIV = 11'b00000000100,
    ST_ALPHA_M1  = 11'b00000001000,
    ST_ALPHA_M2  = 11'b00000010000,
    ST_RED_CHECK = 11'b00000100000,
    ST_RED_MUL   = 11'b00001000000,
    ST_N_DIV     = 11'b00010000000,
    ST_AI_DIV    = 11'b00100000000,
    ST_OUT       = 11'b01000000000,
    ST_SPARE     = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic             start_mode_q;
  logic [PKT_W-1:0] packet_size_q;
  logic [WIN_W-1:0] base_bdp_q, start_window_q, ai_increment_q;
  logic [GAIN_W-1:0] gain_q;

  // flow state
  logic [WIN_W-1:0]    window_q, window_d;
  logic [ALPHA_W-1:0]  alpha_q, alpha_d;
  logic                ss_q, ss_d;
  logic [CNT_W-1:0]    marked_q, marked_d, acks_q, acks_d;
  logic [PSN_BITS-1:0] aum_q, aum_d, rm_q, rm_d;
  logic                aum_valid_q, aum_valid_d;

  // item and scratch
  logic                ecn_q, ecn_d;
  logic [PSN_BITS-1:0] ack_q, ack_d, next_q, next_d;
  logic [ALPHA_W-1:0]  ratio_q, ratio_d;
  logic [P1_W-1:0]     p1_q, p1_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic [GAIN_W-1:0]  gain_eff, one_minus_g;
  logic [PKT_W-1:0]   pkt_eff;
  logic [RED_W-1:0]   red_factor;
  logic [SUM_W-1:0]   alpha_sum;
  logic [DIV_W-1:0]   ceil_q;
  logic [DIV_W-1:0]   n_pkts;
  logic [WIN_W:0]     win_sum;
  logic [WIN_W:0]     ss_sum;

  dcwc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  dcwc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_mode_q    <= 1'b0;
      packet_size_q   <= PKT_W'(1000);
      base_bdp_q      <= WIN_W'(100000);
      start_window_q  <= WIN_W'(100000);
      ai_increment_q  <= WIN_W'(50);
      gain_q          <= GAIN_ONE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_MODE:   start_mode_q   <= cfg_data_i[0];
        CFG_PACKET_SIZE:  packet_size_q  <= cfg_data_i[PKT_W-1:0];
        CFG_BASE_BDP:     base_bdp_q     <= cfg_data_i[WIN_W-1:0];
        CFG_START_WINDOW: start_window_q <= cfg_data_i[WIN_W-1:0];
        CFG_AI_INCREMENT: ai_increment_q <= cfg_data_i[WIN_W-1:0];
        CFG_GAIN:         gain_q         <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gain_eff    = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;
    one_minus_g = GAIN_ONE - gain_eff;
    pkt_eff     = (packet_size_q == '0) ? PKT_W'(1) : packet_size_q;
    red_factor  = RED_ONE - {1'b0, alpha_q};
    alpha_sum   = {1'b0, p1_q} + {1'b0, mul_rsp.prod[P1_W-1:0]};
    ceil_q      = div_rsp.quo + DIV_W'(div_rsp.rem != '0);
    n_pkts      = (ceil_q == '0) ? DIV_W'(1) : ceil_q;
    win_sum     = {1'b0, window_q} + {1'b0, ceil_q};
    ss_sum      = {1'b0, window_q} + (WIN_W + 1)'(packet_size_q);
  end

  always_comb begin
    state_d     = state_q;
    window_d    = window_q;
    alpha_d     = alpha_q;
    ss_d        = ss_q;
    marked_d    = marked_q;
    acks_d      = acks_q;
    aum_d       = aum_q;
    aum_valid_d = aum_valid_q;
    rm_d        = rm_q;
    ecn_d       = ecn_q;
    ack_d       = ack_q;
    next_d      = next_q;
    ratio_d     = ratio_q;
    p1_d        = p1_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    div_req     = '0;
    mul_req     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ecn_d  = in_data_i.ecn_marked;
          ack_d  = in_data_i.ack_psn;
          next_d = in_data_i.sender_next_psn;
          if (item_mode_e'(in_data_i.mode) == MODE_START) begin
            window_d    = start_mode_q ? start_window_q : WIN_W'(packet_size_q);
            ss_d        = !start_mode_q;
            alpha_d     = ALPHA_ONE;
            marked_d    = '0;
            acks_d      = '0;
            aum_d       = '0;
            rm_d        = '0;
            aum_valid_d = 1'b0;
            state_d     = ST_OUT;
          end else begin
            if (in_data_i.ecn_marked && marked_q != CNT_MAX) begin
              marked_d = marked_q + CNT_W'(1);
            end
            if (acks_q != CNT_MAX) begin
              acks_d = acks_q + CNT_W'(1);
            end
            if (ss_q && !in_data_i.ecn_marked && window_q < base_bdp_q) begin
              window_d = ss_sum[WIN_W] ? WIN_MAX : ss_sum[WIN_W-1:0];
              state_d  = ST_OUT;
            end else begin
              ss_d    = 1'b0;
              state_d = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        state_d = ST_RED_CHECK;
        if (ack_q > aum_q) begin
          aum_d       = next_q;
          aum_valid_d = 1'b1;
          if (aum_valid_q) begin
            if (acks_q == '0 || marked_q >= acks_q) begin
              ratio_d     = (acks_q == '0) ? '0 : ALPHA_ONE;
              mul_req.start = 1'b1;
              mul_req.a   = MUL_W'(one_minus_g);
              mul_req.b   = MUL_W'(alpha_q);
              state_d     = ST_ALPHA_M1;
            end else begin
              div_req.start   = 1'b1;
              div_req.rem     = DIV_W'(marked_q);
              div_req.dvd     = '0;
              div_req.divisor = DIV_W'(acks_q);
              div_req.steps   = STEP_W'(ALPHA_FRAC_BITS);
              state_d         = ST_RATIO_DIV;
            end
          end
        end
      end
      ST_RATIO_DIV: begin
        if (div_rsp.done) begin
          ratio_d       = div_rsp.quo[ALPHA_W-1:0];
          mul_req.start = 1'b1;
          mul_req.a     = MUL_W'(one_minus_g);
          mul_req.b     = MUL_W'(alpha_q);
          state_d       = ST_ALPHA_M1;
        end
      end
      ST_ALPHA_M1: begin
        if (mul_rsp.done) begin
          p1_d          = mul_rsp.prod[P1_W-1:0];
          mul_req.start = 1'b1;
          mul_req.a     = MUL_W'(ratio_q);
          mul_req.b     = MUL_W'(gain_eff);
          state_d       = ST_ALPHA_M2;
        end
      end
      ST_ALPHA_M2: begin
        if (mul_rsp.done) begin
          if (alpha_sum[SUM_W-1:GAIN_FRAC] > (SUM_W - GAIN_FRAC)'(ALPHA_ONE)) begin
            alpha_d = ALPHA_ONE;
          end else begin
            alpha_d = alpha_sum[GAIN_FRAC +: ALPHA_W];
          end
          marked_d = '0;
          acks_d   = '0;
          state_d  = ST_RED_CHECK;
        end
      end
      ST_RED_CHECK: begin
        if (ack_q > rm_q) begin
          if (ecn_q) begin
            mul_req.start = 1'b1;
            mul_req.a     = MUL_W'(window_q);
            mul_req.b     = MUL_W'(red_factor);
            state_d       = ST_RED_MUL;
          end else begin
            div_req.start   = 1'b1;
            div_req.rem     = '0;
            div_req.dvd     = DIV_W'(window_q);
            div_req.divisor = DIV_W'(pkt_eff);
            div_req.steps   = STEP_W'(DIV_W);
            state_d         = ST_N_DIV;
          end
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_RED_MUL: begin
        if (mul_rsp.done) begin
          window_d = mul_rsp.prod[ALPHA_FRAC_BITS + 1 +: WIN_W];
          rm_d     = next_q;
          state_d  = ST_OUT;
        end
      end
      ST_N_DIV: begin
        if (div_rsp.done) begin
          div_req.start   = 1'b1;
          div_req.rem     = '0;
          div_req.dvd     = DIV_W'(ai_increment_q);
          div_req.divisor = n_pkts;
          div_req.steps   = STEP_W'(DIV_W);
          state_d         = ST_AI_DIV;
        end
      end
      ST_AI_DIV: begin
        if (div_rsp.done) begin
          window_d = win_sum[WIN_W] ? WIN_MAX : win_sum[WIN_W-1:0];
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_d.window_bytes  = window_q;
          out_d.alpha_value   = alpha_q;
          out_d.in_slow_start = ss_q;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= '0;
      alpha_q     <= ALPHA_ONE;
      ss_q        <= 1'b0;
      marked_q    <= '0;
      acks_q      <= '0;
      aum_q       <= '0;
      aum_valid_q <= 1'b0;
      rm_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      alpha_q     <= alpha_d;
      ss_q        <= ss_d;
      marked_q    <= marked_d;
      acks_q      <= acks_d;
      aum_q       <= aum_d;
      aum_valid_q <= aum_valid_d;
      rm_q        <= rm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ecn_q   <= ecn_d;
    ack_q   <= ack_d;
    next_q  <= next_d;
    ratio_q <= ratio_d;
    p1_q    <= p1_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* tb/dctcp_window_controller_tb.sv */
// testbench for the dctcp window controller: directed table, random flows, predictor check
`timescale 1ns / 1ps

module dctcp_window_controller_tb;
  import dcwc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    logic [31:0] data;
    in_item_t    item;
    bit          typed;
    out_item_t   exp;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // configuration copy
  bit          cfg_start_mode = 1'b0;
  logic [15:0] cfg_pkt = 16'd1000;
  logic [31:0] cfg_bdp = 32'd100000;
  logic [31:0] cfg_start_win = 32'd100000;
  logic [31:0] cfg_ai = 32'd50;
  logic [16:0] cfg_gain = 17'd65536;

  // flow state copy
  logic [63:0] flow_win = '0;
  logic [63:0] flow_alpha = 64'd65536;
  logic [63:0] flow_marked = '0;
  logic [63:0] flow_acks = '0;
  logic [63:0] alpha_mark = '0;
  logic [63:0] cut_mark = '0;
  bit          flow_ss = 1'b0;
  bit          alpha_mark_set = 1'b0;

  out_item_t window_results_due[$];
  out_item_t due_result;
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  bit        idle_on = 1'b1;

  dctcp_window_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] sat_win(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic void refresh_alpha_est();
    logic [63:0] g;
    logic [63:0] ratio;
    g = (cfg_gain > GAIN_ONE) ? 64'(GAIN_ONE) : 64'(cfg_gain);
    ratio = '0;
    if (flow_acks != 0) begin
      ratio = (flow_marked << ALPHA_FRAC_BITS) / flow_acks;
      if (ratio > 64'(ALPHA_ONE)) ratio = 64'(ALPHA_ONE);
    end
    flow_alpha = (flow_alpha * (64'd65536 - g) + g * ratio) >> 16;
    if (flow_alpha > 64'(ALPHA_ONE)) flow_alpha = 64'(ALPHA_ONE);
  endfunction

  function automatic void avoid_step(logic [63:0] ack, logic [63:0] next, bit ecn);
    logic [63:0] p;
    logic [63:0] n;
    if (ack > alpha_mark) begin
      if (alpha_mark_set) begin
        refresh_alpha_est();
        flow_marked = '0;
        flow_acks = '0;
      end
      alpha_mark = next;
      alpha_mark_set = 1'b1;
    end
    if (ack > cut_mark) begin
      if (ecn) begin
        flow_win = (flow_win * ((64'(ALPHA_ONE) << 1) - flow_alpha)) >> (ALPHA_FRAC_BITS + 1);
        cut_mark = next;
      end else begin
        p = (cfg_pkt == 0) ? 64'd1 : 64'(cfg_pkt);
        n = (flow_win + p - 1) / p;
        if (n == 0) n = 1;
        flow_win = sat_win(flow_win + (64'(cfg_ai) + n - 1) / n);
      end
    end
  endfunction

  function automatic out_item_t predict_window_update(in_item_t it);
    out_item_t r;
    if (it.mode == MODE_START) begin
      flow_win = cfg_start_mode ? 64'(cfg_start_win) : 64'(cfg_pkt);
      flow_ss = !cfg_start_mode;
      flow_alpha = 64'(ALPHA_ONE);
      flow_marked = '0;
      flow_acks = '0;
      alpha_mark = '0;
      cut_mark = '0;
      alpha_mark_set = 1'b0;
    end else begin
      if (it.ecn_marked) flow_marked = sat_win(flow_marked + 1);
      flow_acks = sat_win(flow_acks + 1);
      if (flow_ss) begin
        if (it.ecn_marked || flow_win >= 64'(cfg_bdp)) begin
          flow_ss = 1'b0;
          avoid_step(64'(it.ack_psn), 64'(it.sender_next_psn), it.ecn_marked);
        end else begin
          flow_win = sat_win(flow_win + 64'(cfg_pkt));
        end
      end else begin
        avoid_step(64'(it.ack_psn), 64'(it.sender_next_psn), it.ecn_marked);
      end
    end
    r.window_bytes = flow_win[31:0];
    r.alpha_value = flow_alpha[16:0];
    r.in_slow_start = flow_ss;
    return r;
  endfunction

  function automatic in_item_t mk_item(item_mode_e m, bit ecn, logic [23:0] ack,
                                       logic [23:0] next);
    in_item_t it;
    it.mode = m;
    it.ecn_marked = ecn;
    it.ack_psn = ack;
    it.sender_next_psn = next;
    return it;
  endfunction

  function automatic plan_row_t cfg_row(cfg_idx_e idx, logic [31:0] data);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    r.item = '0;
    r.typed = 1'b0;
    r.exp = '0;
    return r;
  endfunction

  function automatic plan_row_t item_row(item_mode_e m, bit ecn, logic [23:0] ack,
                                         logic [23:0] next);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx = CFG_START_MODE;
    r.data = '0;
    r.item = mk_item(m, ecn, ack, next);
    r.typed = 1'b0;
    r.exp = '0;
    return r;
  endfunction

  // row whose result is known up front, alpha still at one
  function automatic plan_row_t checked_row(item_mode_e m, bit ecn, logic [23:0] ack,
                                            logic [23:0] next, logic [31:0] win, bit ss);
    plan_row_t r;
    r = item_row(m, ecn, ack, next);
    r.typed = 1'b1;
    r.exp.window_bytes = win;
    r.exp.alpha_value = ALPHA_ONE;
    r.exp.in_slow_start = ss;
    return r;
  endfunction

  function automatic logic [31:0] pick_cfg(logic [31:0] lo, logic [31:0] hi,
                                           logic [31:0] typ_lo, logic [31:0] typ_hi);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      default: return $urandom_range(typ_hi, typ_lo);
    endcase
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t exp);
    int gap;
    out_item_t pred;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_window_update(it);
    window_results_due.push_back(typed ? exp : pred);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_START_MODE:   cfg_start_mode = data[0];
      CFG_PACKET_SIZE:  cfg_pkt = data[15:0];
      CFG_BASE_BDP:     cfg_bdp = data;
      CFG_START_WINDOW: cfg_start_win = data;
      CFG_AI_INCREMENT: cfg_ai = data;
      CFG_GAIN:         cfg_gain = data[16:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain_results(int settle);
    in_valid_i <= 1'b0;
    while (window_results_due.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // result side stall
  initial begin
    int n;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      n = idle_on ? $urandom_range(0, 11) : 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (window_results_due.size() == 0) begin
        $error("result transfer with no expectation pending");
        mismatch_count++;
      end else begin
        due_result = window_results_due.pop_front();
        if (out_data_o.window_bytes !== due_result.window_bytes) begin
          $error("window_bytes: expected %0d, got %0d",
                 due_result.window_bytes, out_data_o.window_bytes);
          mismatch_count++;
        end
        if (out_data_o.alpha_value !== due_result.alpha_value) begin
          $error("alpha_value: expected %0d, got %0d",
                 due_result.alpha_value, out_data_o.alpha_value);
          mismatch_count++;
        end
        if (out_data_o.in_slow_start !== due_result.in_slow_start) begin
          $error("in_slow_start: expected %0d, got %0d",
                 due_result.in_slow_start, out_data_o.in_slow_start);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    plan_row_t   plan[$];
    int          sent;
    int          phase_len;
    int          ecn_pct;
    int          r;
    logic [23:0] ack_pos;
    logic [24:0] psn_sum;
    in_item_t    it;

    // ack before any start, then slow start and its exit on ecn
    plan.push_back(checked_row(MODE_ACK, 1'b0, 24'd5, 24'd10, 32'd50, 1'b0));
    plan.push_back(checked_row(MODE_START, 1'b0, 24'd0, 24'd0, 32'd1000, 1'b1));
    plan.push_back(checked_row(MODE_ACK, 1'b0, 24'd0, 24'd0, 32'd2000, 1'b1));
    plan.push_back(checked_row(MODE_ACK, 1'b1, 24'd1, 24'd20, 32'd1000, 1'b0));
    plan.push_back(item_row(MODE_ACK, 1'b1, 24'd21, 24'd40));
    plan.push_back(item_row(MODE_ACK, 1'b0, 24'd22, 24'd41));
    // fixed start at the largest window, saturating increase
    plan.push_back(cfg_row(CFG_START_MODE, 32'd1));
    plan.push_back(cfg_row(CFG_START_WINDOW, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(CFG_AI_INCREMENT, 32'hFFFF_FFFF));
    plan.push_back(checked_row(MODE_START, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b0));
    plan.push_back(checked_row(MODE_ACK, 1'b0, 24'd1, 24'd2, 32'hFFFF_FFFF, 1'b0));
    plan.push_back(item_row(MODE_ACK, 1'b1, 24'hFFFFFF, 24'hFFFFFF));
    plan.push_back(item_row(MODE_ACK, 1'b1, 24'hFFFFFF, 24'd0));
    // zero packet size, gain above one
    plan.push_back(cfg_row(CFG_PACKET_SIZE, 32'd0));
    plan.push_back(cfg_row(CFG_START_MODE, 32'd0));
    plan.push_back(cfg_row(CFG_BASE_BDP, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(CFG_GAIN, 32'h1_FFFF));
    plan.push_back(checked_row(MODE_START, 1'b0, 24'd0, 24'd0, 32'd0, 1'b1));
    plan.push_back(checked_row(MODE_ACK, 1'b0, 24'd1, 24'd1, 32'd0, 1'b1));
    plan.push_back(checked_row(MODE_ACK, 1'b1, 24'd3, 24'd9, 32'd0, 1'b0));
    plan.push_back(item_row(MODE_ACK, 1'b0, 24'd10, 24'd12));
    // largest packet, slow start exit at the bdp, zero gain and increase
    plan.push_back(cfg_row(CFG_GAIN, 32'd0));
    plan.push_back(cfg_row(CFG_AI_INCREMENT, 32'd0));
    plan.push_back(cfg_row(CFG_PACKET_SIZE, 32'hFFFF));
    plan.push_back(cfg_row(CFG_BASE_BDP, 32'd100000));
    plan.push_back(checked_row(MODE_START, 1'b0, 24'd0, 24'd0, 32'd65535, 1'b1));
    plan.push_back(checked_row(MODE_ACK, 1'b0, 24'd1, 24'd1, 32'd131070, 1'b1));
    plan.push_back(item_row(MODE_ACK, 1'b0, 24'd2, 24'd7));
    plan.push_back(item_row(MODE_ACK, 1'b1, 24'd8, 24'd9));
    // smallest windows and half gain
    plan.push_back(cfg_row(CFG_START_MODE, 32'd1));
    plan.push_back(cfg_row(CFG_START_WINDOW, 32'd1));
    plan.push_back(cfg_row(CFG_BASE_BDP, 32'd1));
    plan.push_back(cfg_row(CFG_AI_INCREMENT, 32'd1));
    plan.push_back(cfg_row(CFG_GAIN, 32'd32768));
    plan.push_back(checked_row(MODE_START, 1'b0, 24'd0, 24'd0, 32'd1, 1'b0));
    plan.push_back(item_row(MODE_ACK, 1'b1, 24'd4, 24'd6));
    plan.push_back(item_row(MODE_ACK, 1'b0, 24'd7, 24'd8));
    plan.push_back(item_row(MODE_ACK, 1'b0, 24'd0, 24'hFFFFFF));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results(8);
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].exp);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results(8);
      idle_on = ($urandom_range(0, 3) != 0);
      cfg_write(CFG_START_MODE, $urandom_range(0, 1));
      cfg_write(CFG_PACKET_SIZE, pick_cfg(32'd0, 32'hFFFF, 32'd64, 32'd9000));
      cfg_write(CFG_BASE_BDP, pick_cfg(32'd1, 32'hFFFF_FFFF, 32'd1000, 32'd400000));
      cfg_write(CFG_START_WINDOW, pick_cfg(32'd1, 32'hFFFF_FFFF, 32'd1000, 32'd400000));
      cfg_write(CFG_AI_INCREMENT, pick_cfg(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd20000));
      cfg_write(CFG_GAIN, pick_cfg(32'd0, 32'h1_FFFF, 32'd1, 32'd65536));
      phase_len = $urandom_range(20, 80);
      ecn_pct = $urandom_range(0, 40);
      r = 0;
      for (int k = 0; k < phase_len; k++) begin
        if (k != 0) r = $urandom_range(0, 99);
        if (k == 0 || r < 3) begin
          ack_pos = $urandom_range(0, 1) ? 24'($urandom_range(0, 255))
                                         : 24'($urandom_range(0, 24'hFFFF00));
          it = mk_item(MODE_START, 1'($urandom), 24'($urandom), 24'($urandom));
        end else if (r < 8) begin
          // out of order or stale sequence numbers
          it = mk_item(MODE_ACK, 1'($urandom), 24'($urandom), 24'($urandom));
        end else begin
          psn_sum = 25'(ack_pos) + 25'($urandom_range(0, 2));
          ack_pos = (psn_sum > 25'hFFFFFF) ? 24'hFFFFFF : psn_sum[23:0];
          psn_sum = 25'(ack_pos) + 25'($urandom_range(1, 24));
          it = mk_item(MODE_ACK, ($urandom_range(0, 99) < ecn_pct), ack_pos,
                       (psn_sum > 25'hFFFFFF) ? 24'hFFFFFF : psn_sum[23:0]);
        end
        send_item(it, 1'b0, '0);
        sent++;
      end
    end

    drain_results(100);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
